// ===== hdl/vtpy_pkg.sv =====
// Package for the direction vector to pitch and yaw block.
// Holds the arctangent table, fixed-point constants and shared types. No dependencies.
`timescale 1ns / 1ps
package vtpy_pkg;
   localparam int FRAC_GUARD   = 8;
   localparam int TABLE_LEN    = 24;
   localparam int ANGLE_W      = 17;
   localparam int ACC_W        = 28;
   localparam int INV_GAIN_Q16 = 39797;
   localparam int FULL_TURN    = 92160;
   localparam int PITCH_UP     = 90 * 256;
   localparam int PITCH_DOWN   = 270 * 256;
   localparam int HALF_TURN_Q16 = 180 * 65536;

   typedef logic [ANGLE_W-1:0] angle_type;

   function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
      logic signed [ACC_W-1:0] r;
      case (idx)
         0: r = 28'sd2949120;   1: r = 28'sd1740967;  2: r = 28'sd919879;
         3: r = 28'sd466945;    4: r = 28'sd234379;   5: r = 28'sd117304;
         6: r = 28'sd58666;     7: r = 28'sd29335;    8: r = 28'sd14668;
         9: r = 28'sd7334;     10: r = 28'sd3667;    11: r = 28'sd1833;
         12: r = 28'sd917;     13: r = 28'sd458;     14: r = 28'sd229;
         15: r = 28'sd115;     16: r = 28'sd57;      17: r = 28'sd29;
         18: r = 28'sd14;      19: r = 28'sd7;       20: r = 28'sd4;
         21: r = 28'sd2;       22: r = 28'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Rounds an accumulator in units of 2^-16 degree to degrees * 256 in [0, 360).
   function automatic angle_type to_angle(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] r;
      r = (acc + ACC_W'(128)) >>> 8;
      if (r < 0) r = r + ACC_W'(FULL_TURN);
      if (r >= ACC_W'(FULL_TURN)) r = r - ACC_W'(FULL_TURN);
      return r[ANGLE_W-1:0];
   endfunction
endpackage

// ===== hdl/vtpy_stream_if.sv =====
// Valid/ready channel interface with a parameterised payload type.
// Depends on nothing.
`timescale 1ns / 1ps
interface vtpy_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/vtpy_cell.sv =====
// One CORDIC vectoring stage with its own pipeline register.
// Depends on vtpy_pkg.
`timescale 1ns / 1ps
module vtpy_cell #(
   parameter int DW = 34,
   parameter int STAGE = 0,
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [DW-1:0]              x_i,
   input  logic signed [DW-1:0]              y_i,
   input  logic signed [vtpy_pkg::ACC_W-1:0] acc_i,
   input  logic [SIDE_W-1:0]                 side_i,
   output logic signed [DW-1:0]              x_o,
   output logic signed [DW-1:0]              y_o,
   output logic signed [vtpy_pkg::ACC_W-1:0] acc_o,
   output logic [SIDE_W-1:0]                 side_o
);
   import vtpy_pkg::*;
   logic signed [DW-1:0]    x_in, y_in, x_ff, y_ff;
   logic signed [ACC_W-1:0] acc_in, acc_ff;
   logic [SIDE_W-1:0]       side_ff;

   always_comb begin
      if (STAGE >= TABLE_LEN) begin
         x_in = x_i; y_in = y_i; acc_in = acc_i;
      end else if (!y_i[DW-1]) begin
         x_in = x_i + (y_i >>> STAGE);
         y_in = y_i - (x_i >>> STAGE);
         acc_in = acc_i + atan_entry(STAGE);
      end else begin
         x_in = x_i - (y_i >>> STAGE);
         y_in = y_i + (x_i >>> STAGE);
         acc_in = acc_i - atan_entry(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in; y_ff <= y_in; acc_ff <= acc_in; side_ff <= side_i;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign acc_o = acc_ff;
   assign side_o = side_ff;
endmodule

// ===== hdl/vector_to_pitch_yaw.sv =====
// Direction vector to pitch and yaw, two chained CORDIC vectoring pipelines.
// Registers in order: stage 0, the yaw cells, gain product, gain round, the pitch cells, output.
// Throughput: one vector per cycle; the whole pipe stalls when the result is not taken.
// Reset clears the stage valid bits only; data registers are not reset.
// Depends on vtpy_pkg, vtpy_stream_if and vtpy_cell.
`timescale 1ns / 1ps
module vector_to_pitch_yaw #(
   parameter int COORD_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   vtpy_stream_if.sink   req,
   vtpy_stream_if.source rsp
);
   import vtpy_pkg::*;
   localparam int DW = COORD_WIDTH + FRAC_GUARD + 3;
   localparam int NS = CORDIC_STEPS;
   localparam int NV = 2 * NS + 4;
   localparam int SW = 2 * ANGLE_W + 2 * DW + 1;

   logic [NV-1:0] vld_ff, vld_in;
   logic          advance;

   assign advance = !vld_ff[NV-1] || rsp.ready;
   assign req.ready = advance;
   assign vld_in = {vld_ff[NV-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= vld_in;
   end

   // Stage 0: pre-rotation of the left half-plane and vertical-case detection.
   logic signed [COORD_WIDTH-1:0] rx, ry, rz;
   logic signed [DW-1:0] x0_ff, y0_ff, z0_ff;
   logic signed [ACC_W-1:0] a0_ff;
   logic vert_ff;
   angle_type vp_ff;
   assign rx = COORD_WIDTH'(req.payload.dir_x);
   assign ry = COORD_WIDTH'(req.payload.dir_y);
   assign rz = COORD_WIDTH'(req.payload.dir_z);

   always_ff @(posedge clock) begin
      if (advance) begin
         logic signed [DW-1:0] sx, sy;
         sx = DW'(rx) <<< FRAC_GUARD;
         sy = DW'(ry) <<< FRAC_GUARD;
         if (rx < 0) begin
            x0_ff <= -sx; y0_ff <= -sy;
            a0_ff <= (ry >= 0) ? ACC_W'(HALF_TURN_Q16) : -ACC_W'(HALF_TURN_Q16);
         end else begin
            x0_ff <= sx; y0_ff <= sy; a0_ff <= '0;
         end
         z0_ff <= DW'(rz) <<< FRAC_GUARD;
         vert_ff <= (rx == 0) && (ry == 0);
         vp_ff <= (rz > 0) ? ANGLE_W'(PITCH_UP) : ANGLE_W'(PITCH_DOWN);
      end
   end

   // Side data through the yaw chain: z, vertical flag, vertical pitch.
   localparam int S1 = DW + 1 + ANGLE_W;
   logic signed [DW-1:0] yx [NS+1], yy [NS+1];
   logic signed [ACC_W-1:0] ya [NS+1];
   logic [S1-1:0] ys [NS+1];
   assign yx[0] = x0_ff; assign yy[0] = y0_ff; assign ya[0] = a0_ff;
   assign ys[0] = {z0_ff, vert_ff, vp_ff};
   for (genvar i = 0; i < NS; i++) begin : g_yaw
      vtpy_cell #(.DW(DW), .STAGE(i), .SIDE_W(S1)) u_cell (
         .clock(clock), .enable(advance),
         .x_i(yx[i]), .y_i(yy[i]), .acc_i(ya[i]), .side_i(ys[i]),
         .x_o(yx[i+1]), .y_o(yy[i+1]), .acc_o(ya[i+1]), .side_o(ys[i+1]));
   end

   // Gain correction: product registered, then round.
   logic [DW+16-1:0] prod_ff;
   logic [S1-1:0] s2_ff;
   angle_type yaw2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         logic [DW-1:0] m;
         m = yx[NS][DW-1] ? '0 : yx[NS];
         prod_ff <= (DW+16)'(m) * (DW+16)'(INV_GAIN_Q16) + (DW+16)'(32768);
         s2_ff <= ys[NS];
         yaw2_ff <= to_angle(ya[NS]);
      end
   end

   localparam int S2 = 1 + 2 * ANGLE_W;
   logic signed [DW-1:0] px [NS+1], py [NS+1];
   logic signed [ACC_W-1:0] pa [NS+1];
   logic [S2-1:0] ps [NS+1];
   logic signed [DW-1:0] h3_ff, z3_ff;
   logic [S2-1:0] s3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         h3_ff <= DW'(prod_ff >> 16);
         z3_ff <= s2_ff[S1-1 -: DW];
         s3_ff <= {s2_ff[ANGLE_W], s2_ff[ANGLE_W-1:0], yaw2_ff};
      end
   end
   assign px[0] = h3_ff; assign py[0] = z3_ff; assign pa[0] = '0; assign ps[0] = s3_ff;
   for (genvar i = 0; i < NS; i++) begin : g_pitch
      vtpy_cell #(.DW(DW), .STAGE(i), .SIDE_W(S2)) u_cell (
         .clock(clock), .enable(advance),
         .x_i(px[i]), .y_i(py[i]), .acc_i(pa[i]), .side_i(ps[i]),
         .x_o(px[i+1]), .y_o(py[i+1]), .acc_o(pa[i+1]), .side_o(ps[i+1]));
   end

   angle_type pitch_ff, yaw_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         if (ps[NS][S2-1]) begin
            pitch_ff <= ps[NS][2*ANGLE_W-1 -: ANGLE_W];
            yaw_ff <= '0;
         end else begin
            pitch_ff <= to_angle(pa[NS]);
            yaw_ff <= ps[NS][ANGLE_W-1:0];
         end
      end
   end

   assign rsp.valid = vld_ff[NV-1];
   assign rsp.payload.pitch_angle = pitch_ff;
   assign rsp.payload.yaw_angle = yaw_ff;
endmodule

// ===== tb/vtpy_tb_pkg.sv =====
// Transfer types for the vector to pitch and yaw testbench.
// Depends on vtpy_pkg for the angle width.
`timescale 1ns / 1ps
package vtpy_tb_pkg;
   import vtpy_pkg::*;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } direction_type;

   typedef struct packed {
      angle_type pitch_angle;
      angle_type yaw_angle;
   } angles_type;
endpackage

// ===== tb/vector_to_pitch_yaw_checker.sv =====
// Checker for the vector to pitch and yaw block: predicts the angles of every
// accepted vector and compares them with the results. Depends on vtpy_pkg, vtpy_tb_pkg and vtpy_stream_if.
`timescale 1ns / 1ps
module vector_to_pitch_yaw_checker (
   input  logic  clock,
   input  logic  reset,
   vtpy_stream_if req,
   vtpy_stream_if rsp,
   output int    failures,
   output int    pending,
   output int    results_seen,
   output int    vertical_seen
);
   import vtpy_pkg::*;
   import vtpy_tb_pkg::*;

   localparam int STEPS = 16;
   localparam longint ARCTAN_Q16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   angles_type expected_angles[$];

   function automatic longint rotate_to_axis(inout longint a, inout longint b, input longint acc);
      longint da, db;
      for (int i = 0; i < STEPS; i++) begin
         da = b >>> i;
         db = a >>> i;
         if (b >= 0) begin
            a += da; b -= db; acc += ARCTAN_Q16[i];
         end else begin
            a -= da; b += db; acc -= ARCTAN_Q16[i];
         end
      end
      return acc;
   endfunction

   function automatic angle_type round_degrees(input longint acc);
      longint r;
      r = (acc + 128) >>> 8;
      if (r < 0) r += FULL_TURN;
      if (r >= FULL_TURN) r -= FULL_TURN;
      return angle_type'(r);
   endfunction

   function automatic angles_type angles_of(input direction_type d);
      angles_type res;
      longint x, y, z, acc, h;
      x = d.dir_x;
      y = d.dir_y;
      z = d.dir_z;
      if (x == 0 && y == 0) begin
         res.yaw_angle = '0;
         res.pitch_angle = (z > 0) ? angle_type'(PITCH_UP) : angle_type'(PITCH_DOWN);
         return res;
      end
      x *= 256; y *= 256; z *= 256;
      acc = 0;
      // The left half-plane is folded over by a half turn first.
      if (x < 0) begin
         acc = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
         x = -x;
         y = -y;
      end
      acc = rotate_to_axis(x, y, acc);
      res.yaw_angle = round_degrees(acc);
      if (x < 0) x = 0;
      h = (x * INV_GAIN_Q16 + 32768) >>> 16;
      acc = rotate_to_axis(h, z, 0);
      res.pitch_angle = round_degrees(acc);
      return res;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      failures++;
   endtask

   initial begin
      failures = 0;
      results_seen = 0;
      vertical_seen = 0;
   end

   assign pending = expected_angles.size();

   always @(posedge clock) begin
      angles_type want, got;
      direction_type d;
      if (!reset) begin
         if (req.valid && req.ready) begin
            d = req.payload;
            if (d.dir_x == 0 && d.dir_y == 0) vertical_seen++;
            expected_angles.push_back(angles_of(d));
         end
         if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            results_seen++;
            if (expected_angles.size() == 0) begin
               report("unexpected transfer, pitch", got.pitch_angle, -1);
            end else begin
               want = expected_angles.pop_front();
               if (got.pitch_angle !== want.pitch_angle)
                  report("pitch_angle", got.pitch_angle, want.pitch_angle);
               if (got.yaw_angle !== want.yaw_angle)
                  report("yaw_angle", got.yaw_angle, want.yaw_angle);
            end
         end
      end
   end
endmodule

// ===== tb/vector_to_pitch_yaw_test.sv =====
// Top of the vector to pitch and yaw testbench: clock, reset, stimulus and verdict.
// Depends on vtpy_tb_pkg, vtpy_stream_if, the checker and the block.
`timescale 1ns / 1ps
module vector_to_pitch_yaw_test;
   import vtpy_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1700;
   localparam int LATENCY = 2 * 16 + 4;

   logic clock = 0;
   logic reset = 1;
   int   failures, pending, results_seen, vertical_seen;
   int   vectors_sent = 0;
   bit   sending_done = 0;

   vtpy_stream_if #(.payload_type(direction_type)) req ();
   vtpy_stream_if #(.payload_type(angles_type))    rsp ();

   vector_to_pitch_yaw dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   vector_to_pitch_yaw_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .failures(failures),
      .pending(pending), .results_seen(results_seen), .vertical_seen(vertical_seen));

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      req.valid = 0;
      req.payload = '0;
      rsp.ready = 0;
   end

   task automatic send_vector(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input int gap);
      bit taken;
      if (gap > 0) begin
         req.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req.valid = 1;
      req.payload = {x, y, z};
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = req.ready;
         @(negedge clock);
      end
      vectors_sent++;
   endtask

   function automatic logic [15:0] random_component(input int kind);
      case (kind)
         0: return 16'($urandom_range(0, 16) - 8);
         1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Result side: random stalls, plus one long hold-off so the pipe fills.
   initial begin
      int stall;
      bit taken;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = (results_seen == 150) ? 400 : $urandom_range(0, 14);
         if ($urandom_range(0, 3) == 0 && results_seen != 150) stall = 0;
         if (stall > 0) begin
            rsp.ready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready = 1;
         taken = 0;
         while (!taken) begin
            @(posedge clock);
            taken = rsp.valid;
            @(negedge clock);
         end
      end
   end

   initial begin
      int gap, kind;
      logic [15:0] x, y, z;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Vertical vectors, axes, extremes and both halves of the left half-plane.
      send_vector(16'sd0, 16'sd0, 16'sd0, 0);
      send_vector(16'sd0, 16'sd0, 16'sd5, 0);
      send_vector(16'sd0, 16'sd0, -16'sd5, 0);
      send_vector(16'sd0, 16'sd0, 16'h8000, 1);
      send_vector(16'sd0, 16'sd0, 16'h7fff, 0);
      send_vector(16'h7fff, 16'sd0, 16'sd0, 0);
      send_vector(16'h8000, 16'sd0, 16'sd0, 2);
      send_vector(-16'sd1, 16'sd0, 16'sd0, 0);
      send_vector(-16'sd1, -16'sd1, 16'sd1, 0);
      send_vector(16'sd0, 16'h8000, 16'h7fff, 0);
      send_vector(16'sd0, 16'h7fff, 16'h8000, 3);
      send_vector(16'h8000, 16'h8000, 16'h8000, 0);
      send_vector(16'h7fff, 16'h7fff, 16'h7fff, 0);
      send_vector(16'h8000, 16'h7fff, 16'sd0, 0);
      send_vector(16'sd1, 16'sd1, 16'sd1, 0);
      send_vector(-16'sd5, 16'sd3, -16'sd7, 0);
      send_vector(-16'sd5, -16'sd3, 16'sd2, 0);
      send_vector(16'sd1, -16'sd1, 16'sd0, 0);
      send_vector(16'hffff, 16'hffff, 16'hffff, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gap = $urandom_range(0, 14);
         if ($urandom_range(0, 3) == 0 || (n >= 100 && n < 300)) gap = 0;
         kind = $urandom_range(0, 9);
         x = random_component(kind < 2 ? 0 : (kind == 2 ? 1 : 2));
         y = random_component(kind < 2 ? 0 : (kind == 3 ? 1 : 2));
         z = random_component(kind == 4 ? 1 : 2);
         if (kind == 9) begin
            x = 0;
            y = 0;
         end
         send_vector(x, y, z, gap);
      end
      req.valid = 0;
      sending_done = 1;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d vectors, %0d of them vertical; %0d results checked.",
               vectors_sent, vertical_seen, results_seen);
      if (failures == 0)
         $display("[vector_to_pitch_yaw] OK");
      else
         $display("[vector_to_pitch_yaw] ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out with %0d results outstanding.", pending);
      $display("[vector_to_pitch_yaw] ERROR");
      $finish;
   end
endmodule
